// ===== sv/lps_pkg.sv =====
// lps_pkg: shared types and constants for the lid position sequencer.
// Holds the configuration record, the result record and the register map.
// No dependencies.
package lps_pkg;

	localparam int MAX_DRIVE    = 1023;
	localparam int DRIVE_W      = 11;
	localparam int DUTY_W       = 10;
	localparam int MOTOR_W      = 4;
	localparam int POS_W        = 16;
	localparam int GOAL_W       = 16;
	localparam int TICK_W       = 10;
	localparam int SEL_W        = 16;
	localparam int POL_W        = 14;
	localparam int APB_ADDR_W   = 5;
	localparam int APB_DATA_W   = 32;

	// register map, index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_GAIN_HALVES  = 3'd0,
		REG_DEADBAND     = 3'd1,
		REG_MIN_DRIVE    = 3'd2,
		REG_SETTLE_TOL   = 3'd3,
		REG_MOVE_TIMEOUT = 3'd4,
		REG_DWELL_TICKS  = 3'd5,
		REG_OPEN_TARGET  = 3'd6,
		REG_POLARITY     = 3'd7
	} lps_reg_t;

	typedef struct packed {
		logic [7:0]        gain_halves;
		logic [9:0]        deadband;
		logic [9:0]        min_drive;
		logic [9:0]        settle_tolerance;
		logic [TICK_W-1:0] move_timeout;
		logic [TICK_W-1:0] dwell_ticks;
		logic [14:0]       open_target;
		logic [POL_W-1:0]  polarity_mask;
	} lps_cfg_t;

	localparam lps_cfg_t CFG_RESET = '{
		gain_halves:      8'd5,
		deadband:         10'd5,
		min_drive:        10'd150,
		settle_tolerance: 10'd15,
		move_timeout:     10'd200,
		dwell_ticks:      10'd100,
		open_target:      15'd2722,
		polarity_mask:    14'd0
	};

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      bridge_in1;
		logic                      bridge_in2;
		logic [DUTY_W-1:0]         duty;
		logic                      channel_b;
		logic [MOTOR_W-1:0]        motor_now;
		logic [SEL_W-1:0]          select_word;
		logic                      clear_count;
		logic                      busy_res;
		logic                      ack;
	} lps_result_t;

endpackage

// ===== sv/lps_regs.sv =====
// lps_regs: APB configuration register file for the lid position sequencer.
// Depends on lps_pkg (register map, configuration record, reset values).
module lps_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lps_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lps_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lps_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output lps_pkg::lps_cfg_t                cfg
);

	lps_pkg::lps_cfg_t cfg_q;
	lps_pkg::lps_reg_t idx;
	logic              wr_en;

	assign idx    = lps_pkg::lps_reg_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lps_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				lps_pkg::REG_GAIN_HALVES:  cfg_q.gain_halves      <= pwdata[7:0];
				lps_pkg::REG_DEADBAND:     cfg_q.deadband         <= pwdata[9:0];
				lps_pkg::REG_MIN_DRIVE:    cfg_q.min_drive        <= pwdata[9:0];
				lps_pkg::REG_SETTLE_TOL:   cfg_q.settle_tolerance <= pwdata[9:0];
				lps_pkg::REG_MOVE_TIMEOUT: cfg_q.move_timeout     <= pwdata[9:0];
				lps_pkg::REG_DWELL_TICKS:  cfg_q.dwell_ticks      <= pwdata[9:0];
				lps_pkg::REG_OPEN_TARGET:  cfg_q.open_target      <= pwdata[14:0];
				lps_pkg::REG_POLARITY:     cfg_q.polarity_mask    <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lps_pkg::REG_GAIN_HALVES:  prdata = {24'd0, cfg_q.gain_halves};
			lps_pkg::REG_DEADBAND:     prdata = {22'd0, cfg_q.deadband};
			lps_pkg::REG_MIN_DRIVE:    prdata = {22'd0, cfg_q.min_drive};
			lps_pkg::REG_SETTLE_TOL:   prdata = {22'd0, cfg_q.settle_tolerance};
			lps_pkg::REG_MOVE_TIMEOUT: prdata = {22'd0, cfg_q.move_timeout};
			lps_pkg::REG_DWELL_TICKS:  prdata = {22'd0, cfg_q.dwell_ticks};
			lps_pkg::REG_OPEN_TARGET:  prdata = {17'd0, cfg_q.open_target};
			lps_pkg::REG_POLARITY:     prdata = {18'd0, cfg_q.polarity_mask};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== sv/lps_law.sv =====
// lps_law: proportional control law with deadband, minimum drive and polarity.
// Also flags when the position is within settle tolerance of the goal.
// Depends on lps_pkg.
module lps_law (
	input  logic [lps_pkg::GOAL_W-1:0]          goal,
	input  logic signed [lps_pkg::POS_W-1:0]    position,
	input  logic [lps_pkg::MOTOR_W-1:0]         motor,
	input  lps_pkg::lps_cfg_t                   cfg,
	output logic signed [lps_pkg::DRIVE_W-1:0]  drive,
	output logic                                reached
);

	logic signed [17:0] err;
	logic               neg;
	logic [16:0]        mag;
	logic [24:0]        prod;
	logic [23:0]        scaled;
	logic [9:0]         mag_clip;
	logic [9:0]         mag_min;
	logic [9:0]         mag_out;
	logic [15:0]        pol_ext;
	logic               flip;

	always_comb begin
		err      = $signed({2'b00, goal}) - 18'(position);
		neg      = err[17];
		mag      = neg ? 17'(-err) : 17'(err);
		reached  = mag < {7'd0, cfg.settle_tolerance};
		prod     = mag * cfg.gain_halves;
		scaled   = prod[24:1];
		mag_clip = (scaled > 24'(lps_pkg::MAX_DRIVE)) ? 10'(lps_pkg::MAX_DRIVE)
		                                              : scaled[9:0];
		// zero gain leaves zero; minimum only lifts a nonzero magnitude
		mag_min  = (mag_clip != '0 && mag_clip < cfg.min_drive) ? cfg.min_drive : mag_clip;
		mag_out  = (mag < {7'd0, cfg.deadband}) ? 10'd0 : mag_min;
		// motors beyond the mask width are never reversed
		pol_ext  = {2'b00, cfg.polarity_mask};
		flip     = pol_ext[motor];
		drive    = (neg ^ flip) ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
	end

endmodule

// ===== sv/lps_seq.sv =====
// lps_seq: open/dwell/close sequencer state and per-item result formation.
// Instantiates lps_law; depends on lps_pkg.
module lps_seq #(
	parameter int MOTOR_COUNT = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step_en,
	input  logic                              kind,
	input  logic signed [lps_pkg::POS_W-1:0]  position,
	input  lps_pkg::lps_cfg_t                 cfg,
	output lps_pkg::lps_result_t              result
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_OPEN  = 2'd1,
		PH_DWELL = 2'd2,
		PH_CLOSE = 2'd3
	} phase_t;

	phase_t                              phase_q, phase_nxt;
	logic [lps_pkg::TICK_W-1:0]          ticks_q, ticks_nxt, ticks_inc;
	logic [lps_pkg::GOAL_W-1:0]          goal_q, goal_nxt;
	logic [lps_pkg::MOTOR_W-1:0]         motor_q, motor_nxt, motor_wrap;
	logic [lps_pkg::MOTOR_W:0]           motor_inc;
	logic signed [lps_pkg::DRIVE_W-1:0]  drive_raw, drive_fin;
	logic                                reached, mv_done, brake;
	logic [lps_pkg::SEL_W-1:0]           sel;
	logic                                clr;

	lps_law u_law (
		.goal     (goal_q),
		.position (position),
		.motor    (motor_q),
		.cfg      (cfg),
		.drive    (drive_raw),
		.reached  (reached)
	);

	always_comb begin
		ticks_inc  = ticks_q + 1'b1;
		mv_done    = reached || (ticks_inc >= cfg.move_timeout);
		motor_inc  = {1'b0, motor_q} + 1'b1;
		motor_wrap = (motor_inc >= (lps_pkg::MOTOR_W+1)'(MOTOR_COUNT))
		             ? '0 : motor_inc[lps_pkg::MOTOR_W-1:0];

		phase_nxt = phase_q;
		ticks_nxt = ticks_q;
		goal_nxt  = goal_q;
		motor_nxt = motor_q;
		brake     = 1'b0;
		sel       = '0;
		clr       = 1'b0;

		if (kind) begin
			// request: only starts a sequence from idle
			if (phase_q == PH_IDLE) begin
				phase_nxt = PH_OPEN;
				ticks_nxt = '0;
				goal_nxt  = {1'b0, cfg.open_target};
			end
		end else begin
			case (phase_q)
				PH_OPEN: begin
					if (mv_done) begin
						phase_nxt = PH_DWELL;
						ticks_nxt = '0;
					end else begin
						ticks_nxt = ticks_inc;
					end
				end
				PH_DWELL: begin
					if (ticks_inc >= cfg.dwell_ticks) begin
						phase_nxt = PH_CLOSE;
						ticks_nxt = '0;
						goal_nxt  = '0;
					end else begin
						ticks_nxt = ticks_inc;
					end
				end
				PH_CLOSE: begin
					if (mv_done) begin
						brake     = 1'b1;
						motor_nxt = motor_wrap;
						sel       = (16'd1 << motor_wrap[lps_pkg::MOTOR_W-1:1])
						            | {4'd0, motor_wrap, 8'd0};
						clr       = 1'b1;
						phase_nxt = PH_IDLE;
						ticks_nxt = '0;
					end else begin
						ticks_nxt = ticks_inc;
					end
				end
				default: ;
			endcase
		end

		drive_fin = (kind || brake) ? '0 : drive_raw;

		result.drive       = drive_fin;
		result.channel_b   = motor_q[0];
		result.motor_now   = motor_q;
		result.select_word = sel;
		result.clear_count = clr;
		result.busy_res    = (phase_nxt != PH_IDLE);
		result.ack         = kind;
		if (kind) begin
			result.bridge_in1 = 1'b0;
			result.bridge_in2 = 1'b0;
			result.duty       = '0;
		end else if (drive_fin > 0) begin
			result.bridge_in1 = 1'b1;
			result.bridge_in2 = 1'b0;
			result.duty       = drive_fin[lps_pkg::DUTY_W-1:0];
		end else if (drive_fin < 0) begin
			result.bridge_in1 = 1'b0;
			result.bridge_in2 = 1'b1;
			result.duty       = lps_pkg::DUTY_W'(-drive_fin);
		end else begin
			// both pins high: brake
			result.bridge_in1 = 1'b1;
			result.bridge_in2 = 1'b1;
			result.duty       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			goal_q  <= '0;
			motor_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_nxt;
			ticks_q <= ticks_nxt;
			goal_q  <= goal_nxt;
			motor_q <= motor_nxt;
		end
	end

endmodule

// ===== sv/lid_position_sequencer.sv =====
// Lid position sequencer: an accepted request loads the input register, and its result
// then loads the result register when the output can advance; throughput one request per
// cycle unless m_tready back-pressure stalls the output. Control law and sequencer step are one
// combinational pass between the two registers.
// Reset clears valid flags and sequencer state and returns configuration to defaults.
// Depends on lps_pkg, lps_regs, lps_seq (with lps_law).
module lid_position_sequencer #(
	parameter int MOTOR_COUNT = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lps_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lps_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lps_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// requests in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // position[15:0]
	input  logic                             s_tuser,   // kind
	// results out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// drive[10:0], bridge_in1[11], bridge_in2[12], duty[22:13], channel_b[23],
	// motor_now[27:24], select_word[43:28], clear_count[44], busy_res[45], zero[47:46]
	output logic [47:0]                      m_tdata,
	output logic                             m_tuser    // ack
);

	lps_pkg::lps_cfg_t    cfg;
	lps_pkg::lps_result_t res;
	lps_pkg::lps_result_t res_s2;

	logic                             valid_s1, valid_s2;
	logic                             kind_s1;
	logic signed [lps_pkg::POS_W-1:0] pos_s1;
	logic                             adv;

	lps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lps_seq #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (valid_s1 && adv),
		.kind     (kind_s1),
		.position (pos_s1),
		.cfg      (cfg),
		.result   (res)
	);

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			pos_s1  <= $signed(s_tdata);
		end
		if (valid_s1 && adv)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.ack;
	assign m_tdata  = {2'b00, res_s2.busy_res, res_s2.clear_count, res_s2.select_word,
	                   res_s2.motor_now, res_s2.channel_b, res_s2.duty,
	                   res_s2.bridge_in2, res_s2.bridge_in1, res_s2.drive};

endmodule
